@@ src/bhbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte histogram package
// Shared sizes, action codes, command types, sequencer states and counter
// helper functions for the byte histogram bar scaler.
// ----------------------------------------------------------------------------
package bhbs_pkg;

	// Histogram geometry.
	localparam int BINS        = 256;
	localparam int COUNT_WIDTH = 32;
	localparam int BIN_AW      = (BINS > 1) ? $clog2(BINS) : 1;

	// Field widths on the ports.
	localparam int SYM_W   = 8;
	localparam int ACT_W   = 2;
	localparam int SCALE_W = 8;
	localparam int OCC_W   = 32;
	localparam int BAR_W   = SCALE_W + 1;

	// The product scale * count feeds the divider.
	localparam int PROD_W  = SCALE_W + COUNT_WIDTH;
	localparam int DIV_CW  = $clog2(PROD_W + 1);

	// Command queue between the front and the back.
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);

	localparam logic [SYM_W:0]       BINS_LIM    = (SYM_W + 1)'(BINS);
	localparam logic [SCALE_W-1:0]   SCALE_RESET = SCALE_W'(25);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// Action codes on the input channel.
	localparam logic [ACT_W-1:0] ACT_COUNT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REPORT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	// Classified operation carried through the queue.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_COUNT,
		OP_REPORT,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SYM_W-1:0] symbol;
	} cmd_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} bk_state_t;

	// Saturating increment of a counter.
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
	endfunction

	// Count as seen on the 32-bit occurrences field, saturating when wider.
	function automatic logic [OCC_W-1:0] occ_sat(input logic [COUNT_WIDTH-1:0] v);
		logic [47:0] wide;
		wide = 48'(v);
		occ_sat = (wide > 48'hFFFF_FFFF) ? {OCC_W{1'b1}} : wide[OCC_W-1:0];
	endfunction

endpackage

@@ src/byte_histogram_bar_scaler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte histogram bar scaler
// Counts bytes into per-value bins and reports a bin with a scaled bar length.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, action, symbol) carries one command
// per transfer: count a byte, report a bin, or clear every counter. The
// output channel (out_valid, out_stall, bin_index, occurrences, bar_length)
// carries one result per report of a nonzero bin; other commands give none.
// Transfers enter a four-entry command queue, so the input keeps flowing
// while the back end works or while a result waits in the output register.
// In the back end a clear or an ignored command is done in BK_IDLE, a count
// ends in BK_EXEC, and a report of a nonzero bin runs on through BK_MUL,
// BK_DIV and BK_OUT, where the restoring divider yields one quotient
// bit per cycle. The bin store is a single-port-write RAM read once per
// command. Reset clears all bins through per-bin valid bits at once, zeroes
// the total and sets bar_scale to 25; no sweep is needed. When the receiver
// stalls, the result holds steady and the back end waits once it has the
// next result ready; the queue then fills and raises in_stall. cfg_we writes
// bar_scale from cfg_wdata; the user uses it only while idle, unenforced.
// ----------------------------------------------------------------------------
module byte_histogram_bar_scaler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bhbs_pkg::SCALE_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bhbs_pkg::ACT_W-1:0]    action,
	input  logic [bhbs_pkg::SYM_W-1:0]    symbol,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bhbs_pkg::SYM_W-1:0]    bin_index,
	output logic [bhbs_pkg::OCC_W-1:0]    occurrences,
	output logic [bhbs_pkg::BAR_W-1:0]    bar_length
);
	import bhbs_pkg::*;

	logic               scale_q_en;
	logic [SCALE_W-1:0] scale_q;
	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_not_empty;
	cmd_t               push_cmd;
	cmd_t               q_head;

	assign scale_q_en = cfg_we;

	// Bar scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (scale_q_en) begin
			scale_q <= cfg_wdata;
		end
	end

	bhbs_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.symbol   (symbol),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (push_cmd)
	);

	bhbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	bhbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.scale       (scale_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bin_index   (bin_index),
		.occurrences (occurrences),
		.bar_length  (bar_length)
	);

endmodule

@@ src/bhbs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/bhbs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Divides the scaled count by the total, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bhbs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bhbs_pkg::PROD_W-1:0]       dividend,
	input  logic [bhbs_pkg::COUNT_WIDTH-1:0]  divisor,
	output logic                              done,
	output logic [bhbs_pkg::PROD_W-1:0]       quotient
);
	import bhbs_pkg::*;

	logic                   busy_q;
	logic [DIV_CW-1:0]      step_q;
	logic [COUNT_WIDTH:0]   rem_q;
	logic [PROD_W-1:0]      dq_q;
	logic [COUNT_WIDTH-1:0] dvs_q;
	logic [COUNT_WIDTH:0]   rem_sh;
	logic [COUNT_WIDTH:0]   diff;

	// One trial subtraction per step.
	always_comb begin
		rem_sh = {rem_q[COUNT_WIDTH-1:0], dq_q[PROD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DIV_CW'(PROD_W);
			end else if (busy_q) begin
				step_q <= step_q - DIV_CW'(1);
				if (step_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[COUNT_WIDTH]) begin
				rem_q <= diff;
				dq_q  <= {dq_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dq_q  <= {dq_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = dq_q;

endmodule

@@ src/bhbs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module bhbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bhbs_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output bhbs_pkg::cmd_t  head
);
	import bhbs_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   fill_q;

	assign full      = (fill_q == (QAW + 1)'(QDEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QAW + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QAW + 1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

@@ src/bhbs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input front end
// Takes input transfers and classifies each into a queue command.
// ----------------------------------------------------------------------------
module bhbs_front (
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bhbs_pkg::ACT_W-1:0]  action,
	input  logic [bhbs_pkg::SYM_W-1:0]  symbol,
	input  logic                        q_full,
	output logic                        push,
	output bhbs_pkg::cmd_t              cmd
);
	import bhbs_pkg::*;

	logic in_range;

	// Stall only while the queue has no room.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Decode the action; unknown codes and symbols beyond the bins do nothing.
	always_comb begin
		in_range   = ({1'b0, symbol} < BINS_LIM);
		cmd.symbol = symbol;
		unique case (action)
			ACT_COUNT:  cmd.op = in_range ? OP_COUNT : OP_NONE;
			ACT_REPORT: cmd.op = in_range ? OP_REPORT : OP_NONE;
			ACT_CLEAR:  cmd.op = OP_CLEAR;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

@@ src/bhbs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram back end
// Executes queued commands against the bin store, scales reported counts
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module bhbs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  bhbs_pkg::cmd_t                q_head,
	output logic                          q_pop,
	input  logic [bhbs_pkg::SCALE_W-1:0]  scale,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bhbs_pkg::SYM_W-1:0]    bin_index,
	output logic [bhbs_pkg::OCC_W-1:0]    occurrences,
	output logic [bhbs_pkg::BAR_W-1:0]    bar_length
);
	import bhbs_pkg::*;

	bk_state_t              state_q;
	bk_state_t              state_d;
	logic [BINS-1:0]        valid_q;
	logic [COUNT_WIDTH-1:0] total_q;
	op_t                    op_q;
	logic [SYM_W-1:0]       sym_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [PROD_W-1:0]      prod_q;

	logic [BIN_AW-1:0]      ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic                   ram_we;
	logic [COUNT_WIDTH-1:0] cnt_cur;
	logic                   clr_all;
	logic                   bump;
	logic                   take_cnt;
	logic                   div_start;
	logic                   div_done;
	logic [PROD_W-1:0]      div_quo;
	logic                   load_out;
	logic [SCALE_W-1:0]     quo_clamp;

	// Bin store; entries without a valid bit read as zero.
	bhbs_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(1 << BIN_AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sym_q[BIN_AW-1:0]),
		.wdata (sat_inc(cnt_cur)),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bhbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign ram_raddr = q_head.symbol[BIN_AW-1:0];
	assign cnt_cur   = valid_q[sym_q[BIN_AW-1:0]] ? ram_rdata : '0;

	// Quotient limited to the scale; a zero total gives zero.
	always_comb begin
		if (total_q == '0) begin
			quo_clamp = '0;
		end else if (div_quo > PROD_W'(scale)) begin
			quo_clamp = scale;
		end else begin
			quo_clamp = div_quo[SCALE_W-1:0];
		end
	end

	// Sequencer next state and controls.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		clr_all   = 1'b0;
		bump      = 1'b0;
		take_cnt  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_not_empty) begin
					q_pop = 1'b1;
					unique case (q_head.op)
						OP_CLEAR:  clr_all = 1'b1;
						OP_COUNT,
						OP_REPORT: state_d = BK_EXEC;
						default:   state_d = BK_IDLE;
					endcase
				end
			end
			BK_EXEC: begin
				if (op_q == OP_COUNT) begin
					ram_we  = 1'b1;
					bump    = 1'b1;
					state_d = BK_IDLE;
				end else if (cnt_cur == '0) begin
					state_d = BK_IDLE;
				end else begin
					take_cnt = 1'b1;
					state_d  = BK_MUL;
				end
			end
			BK_MUL: begin
				div_start = 1'b1;
				state_d   = BK_DIV;
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control state: sequencer, bin valid bits, total and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			valid_q   <= '0;
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_all) begin
				valid_q <= '0;
				total_q <= '0;
			end else if (bump) begin
				valid_q[sym_q[BIN_AW-1:0]] <= 1'b1;
				total_q <= sat_inc(total_q);
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Command, operand and result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q  <= q_head.op;
			sym_q <= q_head.symbol;
		end
		if (take_cnt) begin
			cnt_q  <= cnt_cur;
			prod_q <= PROD_W'(scale) * PROD_W'(cnt_cur);
		end
		if (load_out) begin
			bin_index   <= sym_q;
			occurrences <= occ_sat(cnt_q);
			bar_length  <= {1'b0, scale} + {1'b0, quo_clamp};
		end
	end

endmodule

@@ src/bhbs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the byte histogram bar scaler over time.
// ----------------------------------------------------------------------------
module bhbs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [bhbs_pkg::SYM_W-1:0]    bin_index,
	input  logic [bhbs_pkg::OCC_W-1:0]    occurrences,
	input  logic [bhbs_pkg::BAR_W-1:0]    bar_length
);

	// No result is offered while reset is held.
	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	// Only nonzero bins are ever reported.
	a_nonzero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occurrences != '0))
		else $error("report of an empty bin");

	// A stalled result stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
		$stable(bin_index) && $stable(occurrences) && $stable(bar_length))
		else $error("result changed while stalled");

endmodule

bind byte_histogram_bar_scaler_core bhbs_checker u_bhbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.bin_index   (bin_index),
	.occurrences (occurrences),
	.bar_length  (bar_length)
);
